// ===== rtl/blfb_pkg.sv =====
package blfb_pkg;

   // Default screen geometry
   localparam int SCREEN_WIDTH_DEF = 128;
   localparam int SCREEN_PAGES_DEF = 8;
   localparam int PAGE_ROWS        = 8;

   // Coordinate and error term widths for the line tracer
   localparam int COORD_W = 19;
   localparam int ERR_W   = 20;
   localparam int PIX_W   = 8;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [ERR_W-1:0]   err_type;

   // Command codes
   typedef enum logic [1:0] {
      OP_DRAW  = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // Top level sequencer
   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_DRAW,
      CTL_CLEAR,
      CTL_READ,
      CTL_FINISH
   } ctl_state_type;

   // Line tracer
   typedef enum logic [2:0] {
      TRC_IDLE,
      TRC_ORDER,
      TRC_MIRROR,
      TRC_EXCH,
      TRC_INIT,
      TRC_STEP
   } trc_state_type;

   // Control half of a framebuffer access (address travels beside it)
   typedef struct packed {
      logic             valid;
      logic             write;
      logic [PIX_W-1:0] mask;
   } acc_ctl_type;

endpackage

// ===== rtl/blfb_tracer.sv =====
module blfb_tracer
   import blfb_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int SCREEN_PAGES = SCREEN_PAGES_DEF,
   parameter int ADDR_W       = $clog2(SCREEN_WIDTH * SCREEN_PAGES)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [15:0] start_x,
   input  logic signed [15:0] start_y,
   input  logic signed [15:0] end_x,
   input  logic signed [15:0] end_y,
   output logic               busy,
   output acc_ctl_type        pix_ctl,
   output logic [ADDR_W-1:0]  pix_addr
);

   localparam int XW  = $clog2(SCREEN_WIDTH);
   localparam int PGW = (SCREEN_PAGES > 1) ? $clog2(SCREEN_PAGES) : 1;
   localparam coord_type W_LIM  = coord_type'(SCREEN_WIDTH);
   localparam coord_type H_LIM  = coord_type'(SCREEN_PAGES * PAGE_ROWS);
   localparam coord_type C_ONE  = coord_type'(1);

   trc_state_type state_ff, state_in;
   coord_type ax_ff, ax_in, ay_ff, ay_in, bx_ff, bx_in, by_ff, by_in;
   coord_type x_ff, x_in, y_ff, y_in, xend_ff, xend_in;
   coord_type dx_ff, dx_in, dy_ff, dy_in;
   err_type   d_ff, d_in, inc_e_ff, inc_e_in, inc_ne_ff, inc_ne_in;
   logic      mir_ff, mir_in, exch_ff, exch_in;
   acc_ctl_type       pix_ctl_ff, pix_ctl_in;
   logic [ADDR_W-1:0] pix_addr_ff, pix_addr_in;

   coord_type ddx, ddy;
   coord_type mx, my;
   logic      on_screen;
   logic [PGW-1:0] pg;
   logic [XW-1:0]  col;

   // Map the octant point back to screen space and locate its byte
   always_comb begin
      if (mir_ff && exch_ff) begin
         mx = y_ff;
         my = -x_ff;
      end else if (mir_ff) begin
         mx = x_ff;
         my = -y_ff;
      end else if (exch_ff) begin
         mx = y_ff;
         my = x_ff;
      end else begin
         mx = x_ff;
         my = y_ff;
      end
      on_screen = (mx >= 0) && (mx < W_LIM) && (my >= 0) && (my < H_LIM);
      pg  = my[PGW+2:3];
      col = mx[XW-1:0];
   end

   assign ddx = bx_ff - ax_ff;
   assign ddy = by_ff - ay_ff;

   // Setup sequence, then one Bresenham step per cycle
   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      ay_in     = ay_ff;
      bx_in     = bx_ff;
      by_in     = by_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      xend_in   = xend_ff;
      dx_in     = dx_ff;
      dy_in     = dy_ff;
      d_in      = d_ff;
      inc_e_in  = inc_e_ff;
      inc_ne_in = inc_ne_ff;
      mir_in    = mir_ff;
      exch_in   = exch_ff;
      unique case (state_ff)
         TRC_IDLE: begin
            if (start) begin
               ax_in    = coord_type'(start_x);
               ay_in    = coord_type'(start_y);
               bx_in    = coord_type'(end_x);
               by_in    = coord_type'(end_y);
               state_in = TRC_ORDER;
            end
         end
         TRC_ORDER: begin
            // order endpoints by x
            if (ax_ff > bx_ff) begin
               ax_in = bx_ff;
               ay_in = by_ff;
               bx_in = ax_ff;
               by_in = ay_ff;
            end
            state_in = TRC_MIRROR;
         end
         TRC_MIRROR: begin
            // falling line: mirror y
            mir_in = (ay_ff > by_ff);
            if (ay_ff > by_ff) begin
               ay_in = -ay_ff;
               by_in = -by_ff;
            end
            state_in = TRC_EXCH;
         end
         TRC_EXCH: begin
            // steep line: swap the axes
            exch_in = (ddy > ddx);
            if (ddy > ddx) begin
               x_in    = ay_ff;
               y_in    = ax_ff;
               xend_in = by_ff;
               dx_in   = ddy;
               dy_in   = ddx;
            end else begin
               x_in    = ax_ff;
               y_in    = ay_ff;
               xend_in = bx_ff;
               dx_in   = ddx;
               dy_in   = ddy;
            end
            state_in = TRC_INIT;
         end
         TRC_INIT: begin
            inc_e_in  = err_type'(dy_ff) + err_type'(dy_ff);
            inc_ne_in = (err_type'(dy_ff) - err_type'(dx_ff))
                      + (err_type'(dy_ff) - err_type'(dx_ff));
            d_in      = err_type'(dy_ff) + err_type'(dy_ff) - err_type'(dx_ff);
            state_in  = TRC_STEP;
         end
         TRC_STEP: begin
            if (x_ff == xend_ff) begin
               state_in = TRC_IDLE;
            end else begin
               x_in = x_ff + C_ONE;
               if (d_ff < 0) begin
                  d_in = d_ff + inc_e_ff;
               end else begin
                  y_in = y_ff + C_ONE;
                  d_in = d_ff + inc_ne_ff;
               end
            end
         end
         default: state_in = TRC_IDLE;
      endcase

      // pixel of the current step, skipped when off screen
      pix_ctl_in.valid = (state_ff == TRC_STEP) && on_screen;
      pix_ctl_in.write = 1'b1;
      pix_ctl_in.mask  = PIX_W'(1) << my[2:0];
      pix_addr_in      = ADDR_W'(pg) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(col);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= TRC_IDLE;
         pix_ctl_ff.valid <= 1'b0;
      end else begin
         state_ff         <= state_in;
         pix_ctl_ff       <= pix_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff           <= ax_in;
      ay_ff           <= ay_in;
      bx_ff           <= bx_in;
      by_ff           <= by_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      xend_ff         <= xend_in;
      dx_ff           <= dx_in;
      dy_ff           <= dy_in;
      d_ff            <= d_in;
      inc_e_ff        <= inc_e_in;
      inc_ne_ff       <= inc_ne_in;
      mir_ff          <= mir_in;
      exch_ff         <= exch_in;
      pix_addr_ff     <= pix_addr_in;
   end

   assign busy     = (state_ff != TRC_IDLE) || pix_ctl_ff.valid;
   assign pix_ctl  = pix_ctl_ff;
   assign pix_addr = pix_addr_ff;

endmodule

// ===== rtl/blfb_store.sv =====
module blfb_store
   import blfb_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int SCREEN_PAGES = SCREEN_PAGES_DEF,
   parameter int ADDR_W       = $clog2(SCREEN_WIDTH * SCREEN_PAGES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear_start,
   input  acc_ctl_type       acc_ctl,
   input  logic [ADDR_W-1:0] acc_addr,
   output logic              busy,
   output logic              rd_valid,
   output logic [PIX_W-1:0]  rd_data
);

   localparam int DEPTH = SCREEN_WIDTH * SCREEN_PAGES;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [PIX_W-1:0] frame_mem [DEPTH];
   logic [PIX_W-1:0] mem_rd_ff;

   acc_ctl_type       s1_ctl_ff, s1_ctl_in;
   logic [ADDR_W-1:0] s1_addr_ff, s1_addr_in;
   logic              fwd_valid_ff, fwd_valid_in;
   logic [ADDR_W-1:0] fwd_addr_ff, fwd_addr_in;
   logic [PIX_W-1:0]  fwd_data_ff, fwd_data_in;
   logic              clr_ff, clr_in;
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic             fwd_hit;
   logic             do_plot;
   logic [PIX_W-1:0] cur_data;
   logic [PIX_W-1:0] wr_data;

   // Second stage: merge read data with last cycle's write, set the pixel
   always_comb begin
      fwd_hit  = fwd_valid_ff && (fwd_addr_ff == s1_addr_ff);
      cur_data = fwd_hit ? fwd_data_ff : mem_rd_ff;
      wr_data  = cur_data | s1_ctl_ff.mask;
      do_plot  = s1_ctl_ff.valid && s1_ctl_ff.write;
   end

   // Next state for stage, forwarding and clearing sweep
   always_comb begin
      s1_ctl_in    = acc_ctl;
      s1_addr_in   = acc_addr;
      fwd_valid_in = do_plot;
      fwd_addr_in  = s1_addr_ff;
      fwd_data_in  = wr_data;
      clr_in       = clr_ff;
      clr_cnt_in   = clr_cnt_ff;
      if (clr_ff) begin
         if (clr_cnt_ff == LAST_ADDR) begin
            clr_in = 1'b0;
         end else begin
            clr_cnt_in = clr_cnt_ff + ADDR_W'(1);
         end
      end else if (clear_start) begin
         clr_in     = 1'b1;
         clr_cnt_in = '0;
      end
   end

   // Framebuffer memory: one read port, one write port
   always_ff @(posedge clock) begin
      mem_rd_ff <= frame_mem[acc_addr];
      if (clr_ff) begin
         frame_mem[clr_cnt_ff] <= '0;
      end else if (do_plot) begin
         frame_mem[s1_addr_ff] <= wr_data;
      end
   end

   // Reset starts a clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         fwd_valid_ff    <= 1'b0;
         clr_ff          <= 1'b1;
         clr_cnt_ff      <= '0;
      end else begin
         s1_ctl_ff       <= s1_ctl_in;
         fwd_valid_ff    <= fwd_valid_in;
         clr_ff          <= clr_in;
         clr_cnt_ff      <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff      <= s1_addr_in;
      fwd_addr_ff     <= fwd_addr_in;
      fwd_data_ff     <= fwd_data_in;
   end

   assign busy     = clr_ff || s1_ctl_ff.valid;
   assign rd_valid = s1_ctl_ff.valid && !s1_ctl_ff.write;
   assign rd_data  = cur_data;

   // no access may be issued while the sweep owns the write port
   assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !acc_ctl.valid)
      else $error("access issued during clearing sweep");

   // a clear only starts once the pipeline is empty
   assert property (@(posedge clock) disable iff (reset)
      clear_start |-> !s1_ctl_ff.valid && !clr_ff)
      else $error("clear started with work in flight");

   // sweep ends only after writing the last entry
   assert property (@(posedge clock) disable iff (reset)
      $fell(clr_ff) |-> $past(clr_cnt_ff) == LAST_ADDR)
      else $error("clearing sweep ended early");

endmodule

// ===== rtl/bresenham_line_framebuffer_unit.sv =====
// Channel | Dir | Handshake             | Payload
// req     | in  | req_valid/req_ready   | op, start_x/y, end_x/y, read_page, read_column
// rsp     | out | rsp_valid/rsp_ready   | read_data (byte for read, zero otherwise)
//
// One item at a time. Draw line: the accepting cycle and the setup steps (order,
// mirror, exchange, init), then one trace step per pixel (one pixel read-modify-write
// per cycle), then the drain and the staging of the result.
// Clear: a sweep over all SCREEN_WIDTH*SCREEN_PAGES bytes (1024 by default), then staging.
// Read: accept, memory read, stage the result.
// After reset a clearing sweep over all SCREEN_WIDTH*SCREEN_PAGES bytes runs; req_ready
// stays low until it ends. A held result stalls only the staging of the next one.
module bresenham_line_framebuffer_unit
   import blfb_pkg::*;
#(
   parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
   parameter int SCREEN_PAGES = SCREEN_PAGES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic [2:0]         req_read_page,
   input  logic [6:0]         req_read_column,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_read_data
);

   localparam int ADDR_W = $clog2(SCREEN_WIDTH * SCREEN_PAGES);

   ctl_state_type     state_ff, state_in;
   logic [PIX_W-1:0]  res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]  rsp_read_data_ff, rsp_read_data_in;

   logic              accept;
   logic              rd_in_range;
   logic              trc_start;
   logic              trc_busy;
   acc_ctl_type       trc_pix_ctl;
   logic [ADDR_W-1:0] trc_pix_addr;
   logic              clear_start;
   acc_ctl_type       rd_ctl;
   logic [ADDR_W-1:0] rd_addr;
   acc_ctl_type       acc_ctl;
   logic [ADDR_W-1:0] acc_addr;
   logic              sto_busy;
   logic              sto_rd_valid;
   logic [PIX_W-1:0]  sto_rd_data;
   logic              load;

   assign req_ready   = (state_ff == CTL_IDLE) && !sto_busy;
   assign accept      = req_valid && req_ready;
   assign rd_in_range = (32'(req_read_page) < SCREEN_PAGES)
                     && (32'(req_read_column) < SCREEN_WIDTH);
   assign rd_addr     = ADDR_W'(req_read_page) * ADDR_W'(SCREEN_WIDTH)
                      + ADDR_W'(req_read_column);

   // Command sequencer
   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      trc_start    = 1'b0;
      clear_start  = 1'b0;
      rd_ctl.valid = 1'b0;
      rd_ctl.write = 1'b0;
      rd_ctl.mask  = '0;
      load         = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               res_in = '0;
               unique case (op_type'(req_op))
                  OP_DRAW: begin
                     trc_start = 1'b1;
                     state_in  = CTL_DRAW;
                  end
                  OP_CLEAR: begin
                     clear_start = 1'b1;
                     state_in    = CTL_CLEAR;
                  end
                  OP_READ: begin
                     if (rd_in_range) begin
                        rd_ctl.valid = 1'b1;
                        state_in     = CTL_READ;
                     end else begin
                        state_in = CTL_FINISH;
                     end
                  end
                  default: state_in = CTL_FINISH;
               endcase
            end
         end
         CTL_DRAW: begin
            if (!trc_busy && !sto_busy) begin
               state_in = CTL_FINISH;
            end
         end
         CTL_CLEAR: begin
            if (!sto_busy) begin
               state_in = CTL_FINISH;
            end
         end
         CTL_READ: begin
            res_in   = sto_rd_data;
            state_in = CTL_FINISH;
         end
         CTL_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = CTL_IDLE;
            end
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // Output register
   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_read_data_in = rsp_read_data_ff;
      if (load) begin
         rsp_valid_in     = 1'b1;
         rsp_read_data_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff           <= res_in;
      rsp_read_data_ff <= rsp_read_data_in;
   end

   // Memory access: tracer pixels, else the read request
   assign acc_ctl  = trc_pix_ctl.valid ? trc_pix_ctl : rd_ctl;
   assign acc_addr = trc_pix_ctl.valid ? trc_pix_addr : rd_addr;

   blfb_tracer #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_PAGES (SCREEN_PAGES),
      .ADDR_W       (ADDR_W)
   ) u_tracer (
      .clock    (clock),
      .reset    (reset),
      .start    (trc_start),
      .start_x  (req_start_x),
      .start_y  (req_start_y),
      .end_x    (req_end_x),
      .end_y    (req_end_y),
      .busy     (trc_busy),
      .pix_ctl  (trc_pix_ctl),
      .pix_addr (trc_pix_addr)
   );

   blfb_store #(
      .SCREEN_WIDTH (SCREEN_WIDTH),
      .SCREEN_PAGES (SCREEN_PAGES),
      .ADDR_W       (ADDR_W)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .clear_start (clear_start),
      .acc_ctl     (acc_ctl),
      .acc_addr    (acc_addr),
      .busy        (sto_busy),
      .rd_valid    (sto_rd_valid),
      .rd_data     (sto_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_read_data_ff;

   // result is only staged once all memory work is done
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == CTL_FINISH) |-> !trc_busy && !sto_busy)
      else $error("result staged with work in flight");

   // read data shows up exactly when a read is waited for
   assert property (@(posedge clock) disable iff (reset)
      sto_rd_valid |-> (state_ff == CTL_READ))
      else $error("unexpected read data from store");

   // pixels only come out while drawing
   assert property (@(posedge clock) disable iff (reset)
      trc_pix_ctl.valid |-> (state_ff == CTL_DRAW))
      else $error("pixel issued outside a draw");

endmodule

// ===== bench/blfb_line_checker.sv =====
module blfb_line_checker
   import blfb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic [2:0]         req_read_page,
   input  logic [6:0]         req_read_column,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_read_data,
   output int                 mismatches,
   output int                 outstanding
);

   localparam int WIDTH  = SCREEN_WIDTH_DEF;
   localparam int PAGES  = SCREEN_PAGES_DEF;
   localparam int HEIGHT = SCREEN_PAGES_DEF * PAGE_ROWS;
   localparam int DEPTH  = SCREEN_WIDTH_DEF * SCREEN_PAGES_DEF;

   // shadow copy of the framebuffer, page-major byte columns
   logic [7:0] shadow_fb [DEPTH];
   // bytes still owed by the block, oldest first
   logic [7:0] pending_bytes [$];
   int         err_count = 0;

   function automatic void wipe_shadow();
      foreach (shadow_fb[i])
         shadow_fb[i] = '0;
   endfunction

   // off-screen pixels are dropped
   function automatic void set_pixel(int x, int y);
      if (x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT)
         shadow_fb[(y / PAGE_ROWS) * WIDTH + x][y % PAGE_ROWS] = 1'b1;
   endfunction

   // undo the octant folding before plotting
   function automatic void set_folded(int x, int y, bit mirror, bit swap_xy);
      if (mirror && swap_xy)
         set_pixel(y, -x);
      else if (mirror)
         set_pixel(x, -y);
      else if (swap_xy)
         set_pixel(y, x);
      else
         set_pixel(x, y);
   endfunction

   function automatic void trace_line(int x0, int y0, int x1, int y1);
      int  t, x, y, dx, dy, err, step_e, step_ne;
      bit  mirror, swap_xy;
      mirror  = 1'b0;
      swap_xy = 1'b0;
      // horizontal span
      if (y0 == y1) begin
         if (x0 > x1) begin
            t = x0; x0 = x1; x1 = t;
         end
         for (x = x0; x <= x1; x++)
            set_pixel(x, y0);
         return;
      end
      // vertical span
      if (x0 == x1) begin
         if (y0 > y1) begin
            t = y0; y0 = y1; y1 = t;
         end
         for (y = y0; y <= y1; y++)
            set_pixel(x0, y);
         return;
      end
      // fold into the first octant
      if (x0 > x1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      if (y0 > y1) begin
         y0     = -y0;
         y1     = -y1;
         mirror = 1'b1;
      end
      if (y1 - y0 > x1 - x0) begin
         t = x0; x0 = y0; y0 = t;
         t = x1; x1 = y1; y1 = t;
         swap_xy = 1'b1;
      end
      dx      = x1 - x0;
      dy      = y1 - y0;
      step_e  = 2 * dy;
      step_ne = 2 * (dy - dx);
      err     = 2 * dy - dx;
      x       = x0;
      y       = y0;
      set_folded(x, y, mirror, swap_xy);
      while (x < x1) begin
         x++;
         if (err < 0) begin
            err += step_e;
         end else begin
            y++;
            err += step_ne;
         end
         set_folded(x, y, mirror, swap_xy);
      end
   endfunction

   // apply one command to the shadow buffer, return the byte it answers with
   function automatic logic [7:0] apply_command(
      logic [1:0] op, logic signed [15:0] sx, logic signed [15:0] sy,
      logic signed [15:0] ex, logic signed [15:0] ey,
      logic [2:0] page, logic [6:0] column);
      logic [7:0] answer;
      answer = '0;
      case (op)
         OP_DRAW:  trace_line(int'(sx), int'(sy), int'(ex), int'(ey));
         OP_CLEAR: wipe_shadow();
         OP_READ: begin
            if (int'(page) < PAGES && int'(column) < WIDTH)
               answer = shadow_fb[int'(page) * WIDTH + int'(column)];
         end
         default: ;
      endcase
      return answer;
   endfunction

   initial wipe_shadow();

   // predict on accepted items, compare on accepted results
   always @(posedge clock) begin
      logic [7:0] want;
      if (reset) begin
         pending_bytes.delete();
         wipe_shadow();
         outstanding <= 0;
      end else begin
         if (req_valid && req_ready)
            pending_bytes.push_back(apply_command(req_op, req_start_x, req_start_y,
               req_end_x, req_end_y, req_read_page, req_read_column));
         if (rsp_valid && rsp_ready) begin
            if (pending_bytes.size() == 0) begin
               err_count++;
               $error("read_data: expected nothing, actual 0x%02h", rsp_read_data);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_read_data !== want) begin
                  err_count++;
                  $error("read_data: expected 0x%02h, actual 0x%02h", want, rsp_read_data);
               end
            end
         end
         outstanding <= pending_bytes.size();
      end
      mismatches <= err_count;
   end

endmodule

// ===== bench/tb_bresenham_line_framebuffer_unit.sv =====
module tb_bresenham_line_framebuffer_unit
   import blfb_pkg::*;
;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         RANDOM_CNT  = 1880;
   localparam int         HOLD_CYCLES = 2500;
   localparam int         CYCLE_LIMIT = 4000000;

   logic               clock;
   logic               reset           = 1'b1;
   logic               req_valid       = 1'b0;
   logic               req_ready;
   logic [1:0]         req_op          = '0;
   logic signed [15:0] req_start_x     = '0;
   logic signed [15:0] req_start_y     = '0;
   logic signed [15:0] req_end_x       = '0;
   logic signed [15:0] req_end_y       = '0;
   logic [2:0]         req_read_page   = '0;
   logic [6:0]         req_read_column = '0;
   logic               rsp_valid;
   logic               rsp_ready       = 1'b0;
   logic [7:0]         rsp_read_data;

   int   mismatches;
   int   outstanding;
   int   cycle_count  = 0;
   logic no_idle      = 1'b0;
   logic hold_request = 1'b0;

   bresenham_line_framebuffer_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_read_page(req_read_page), .req_read_column(req_read_column),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_data(rsp_read_data)
   );

   blfb_line_checker line_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_start_x(req_start_x), .req_start_y(req_start_y),
      .req_end_x(req_end_x), .req_end_y(req_end_y),
      .req_read_page(req_read_page), .req_read_column(req_read_column),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_read_data(rsp_read_data),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 37);
         end
      end
   end

   function automatic logic signed [15:0] clamp16(int v);
      if (v > 32767)
         return 16'sh7fff;
      if (v < -32768)
         return 16'sh8000;
      return v[15:0];
   endfunction

   // present one item, called at a rising edge, returns at its accepting edge
   task automatic offer(logic [1:0] op, logic signed [15:0] sx, logic signed [15:0] sy,
                        logic signed [15:0] ex, logic signed [15:0] ey,
                        logic [2:0] page, logic [6:0] column);
      if (!no_idle) begin
         while ($urandom_range(99) < 37) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_start_x     <= sx;
      req_start_y     <= sy;
      req_end_x       <= ex;
      req_end_y       <= ey;
      req_read_page   <= page;
      req_read_column <= column;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic draw(int sx, int sy, int ex, int ey);
      offer(OP_DRAW, clamp16(sx), clamp16(sy), clamp16(ex), clamp16(ey),
            3'($urandom), 7'($urandom));
   endtask

   task automatic read_byte(int page, int column);
      offer(OP_READ, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            3'(page), 7'(column));
   endtask

   task automatic other_op(logic [1:0] op);
      offer(op, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
            3'($urandom), 7'($urandom));
   endtask

   // stop offering until every result is back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic random_item();
      int pick, kind, x0, y0, x1, y1;
      pick = $urandom_range(99);
      if (pick < 2) begin
         other_op(OP_CLEAR);
      end else if (pick < 4) begin
         other_op(OP_UNUSED);
      end else if (pick < 40) begin
         read_byte($urandom_range(7), $urandom_range(127));
      end else begin
         // mostly near-screen lines, a share of spans, points and far-away short lines
         kind = $urandom_range(99);
         x0 = int'($urandom_range(167)) - 20;
         y0 = int'($urandom_range(87)) - 12;
         x1 = int'($urandom_range(167)) - 20;
         y1 = int'($urandom_range(87)) - 12;
         if (kind < 8) begin
            y1 = y0;
         end else if (kind < 16) begin
            x1 = x0;
         end else if (kind < 22) begin
            x1 = x0;
            y1 = y0;
         end else if (kind < 36) begin
            x0 = int'($signed(16'($urandom)));
            y0 = int'($signed(16'($urandom)));
            x1 = x0 + int'($urandom_range(40)) - 20;
            y1 = y0 + int'($urandom_range(40)) - 20;
         end
         draw(x0, y0, x1, y1);
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: fresh buffer, single point, full-range spans and diagonal
      read_byte(0, 0);
      draw(0, 0, 0, 0);
      read_byte(0, 0);
      draw(32767, 63, -32768, 63);
      draw(127, 32767, 127, -32768);
      draw(-32768, 32767, 32767, -32768);
      read_byte(7, 0);
      read_byte(7, 127);
      read_byte(0, 127);
      // octant folding: steep, shallow falling, steep reversed, off screen, steep falling
      draw(10, 0, 13, 63);
      draw(0, 50, 120, 3);
      draw(100, 60, 90, 2);
      draw(-100, -100, -50, -20);
      draw(-5, 70, 20, -10);
      read_byte(1, 10);
      read_byte(3, 60);
      read_byte(6, 91);
      other_op(OP_UNUSED);
      read_byte(0, 1);
      other_op(OP_CLEAR);
      read_byte(7, 127);
      read_byte(0, 0);
      drain();

      // random phase with a stretch without idle gaps, a hold-off and a mid-run pause
      for (int n = 0; n < RANDOM_CNT; n++) begin
         if (n == 500)
            hold_request <= 1'b1;
         if (n == 900)
            no_idle <= 1'b1;
         if (n == 1150)
            no_idle <= 1'b0;
         if (n == 1400)
            drain();
         random_item();
      end
      drain();
      repeat (64) @(posedge clock);

      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/blfb_pkg.sv
rtl/blfb_tracer.sv
rtl/blfb_store.sv
rtl/bresenham_line_framebuffer_unit.sv
bench/blfb_line_checker.sv
bench/tb_bresenham_line_framebuffer_unit.sv
